FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define MPFD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define MPFD_ASSERT(lbl, clk, rst_n, prop)
`define MPFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/mpfd_pkg.sv
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared types and constants of the page framebuffer drawer.
// ----------------------------------------------------------------------------
package mpfd_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int MODE_W  = 3;
    localparam int COORD_W = 16;
    localparam int INDEX_W = 10;
    localparam int PIXEL_W = 8;

    // geometry width: holds x + w - 1 + 1 for any 16-bit inputs
    localparam int GW        = COORD_W + 2;
    localparam int PAGE_SHIFT = 3;

    localparam logic [PIXEL_W-1:0] BYTE_ALL  = 8'hFF;
    localparam logic [2:0]         BIT_LAST  = 3'd7;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 3'd0,
        MODE_PIXEL   = 3'd1,
        MODE_HLINE   = 3'd2,
        MODE_VLINE   = 3'd3,
        MODE_OUTLINE = 3'd4,
        MODE_FILL    = 3'd5,
        MODE_READ    = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        SEG_FILL,
        SEG_TOP,
        SEG_BOTTOM,
        SEG_LEFT,
        SEG_RIGHT,
        SEG_DOT
    } seg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_START,
        ST_WALK,
        ST_READ,
        ST_READ_DATA
    } state_t;

    typedef struct packed {
        logic capture;
        logic clip;
        logic start;
        logic load_all;
        logic init;
        logic step;
        logic read_issue;
        logic out_load;
        seg_t seg;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/mpfd_in_if.sv
// ----------------------------------------------------------------------------
// mpfd_in_if
// Command channel: valid/ready handshake with one drawing command per item.
// ----------------------------------------------------------------------------
interface mpfd_in_if;
    import mpfd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] span_width;
    logic signed [COORD_W-1:0] span_height;
    logic                      ink;
    logic [INDEX_W-1:0]        byte_index;

    modport source (
        output valid, mode, x_pos, y_pos, span_width, span_height, ink, byte_index,
        input  ready
    );

    modport sink (
        input  valid, mode, x_pos, y_pos, span_width, span_height, ink, byte_index,
        output ready
    );
endinterface

FILE: rtl/mpfd_out_if.sv
// ----------------------------------------------------------------------------
// mpfd_out_if
// Read-back channel: valid/ready handshake with one store byte per item.
// ----------------------------------------------------------------------------
interface mpfd_out_if;
    import mpfd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_byte;

    modport source (
        output valid, pixel_byte,
        input  ready
    );

    modport sink (
        input  valid, pixel_byte,
        output ready
    );
endinterface

FILE: rtl/mpfd_ctrl.sv
// ----------------------------------------------------------------------------
// mpfd_ctrl
// Command sequencer: decodes each item into rectangle segments and steps
// the datapath through clip, walk and read-back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2:0]           in_mode,
    output logic                 in_ready,
    output mpfd_pkg::dp_cmd_t    dp_cmd,
    input  mpfd_pkg::dp_status_t dp_status
);
    import mpfd_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    seg_t       seg_reg;
    seg_t       seg_next;
    logic       more_segs;
    seg_t       seg_follow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            mode_reg  <= MODE_CLEAR;
            seg_reg   <= SEG_FILL;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            seg_reg   <= seg_next;
        end
    end

    // outline runs top, bottom, left, right
    always_comb
    begin
        case (seg_reg)
            SEG_TOP:    seg_follow = SEG_BOTTOM;
            SEG_BOTTOM: seg_follow = SEG_LEFT;
            default:    seg_follow = SEG_RIGHT;
        endcase
        more_segs = (mode_reg == MODE_OUTLINE) && (seg_reg != SEG_RIGHT);
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        seg_next   = seg_reg;
        dp_cmd     = '0;
        dp_cmd.seg = seg_reg;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                dp_cmd.load_all = 1'b1;
                dp_cmd.init     = 1'b1;
                state_next      = ST_WALK;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    mode_next      = in_mode;
                    unique case (in_mode)
                        MODE_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        MODE_PIXEL:
                        begin
                            seg_next   = SEG_DOT;
                            state_next = ST_SETUP;
                        end
                        MODE_HLINE, MODE_OUTLINE:
                        begin
                            seg_next   = SEG_TOP;
                            state_next = ST_SETUP;
                        end
                        MODE_VLINE:
                        begin
                            seg_next   = SEG_LEFT;
                            state_next = ST_SETUP;
                        end
                        MODE_FILL:
                        begin
                            seg_next   = SEG_FILL;
                            state_next = ST_SETUP;
                        end
                        MODE_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                dp_cmd.load_all = 1'b1;
                state_next      = ST_WALK;
            end
            ST_SETUP:
            begin
                dp_cmd.clip = 1'b1;
                state_next  = ST_START;
            end
            ST_START:
            begin
                dp_cmd.start = 1'b1;
                if (!dp_status.empty)
                begin
                    state_next = ST_WALK;
                end
                else if (more_segs)
                begin
                    seg_next   = seg_follow;
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                dp_cmd.step = 1'b1;
                if (dp_status.last)
                begin
                    if (more_segs)
                    begin
                        seg_next   = seg_follow;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                dp_cmd.read_issue = 1'b1;
                state_next        = ST_READ_DATA;
            end
            ST_READ_DATA:
            begin
                dp_cmd.read_issue = 1'b1;
                if (dp_status.out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `MPFD_ASSERT_ALWAYS(a_step_read_excl, clk, !(dp_cmd.step && dp_cmd.read_issue))
    `MPFD_ASSERT(a_outline_order, clk, rst_n, (state_reg == ST_SETUP && mode_reg == MODE_OUTLINE) |-> (seg_reg != SEG_FILL && seg_reg != SEG_DOT))
    `MPFD_ASSERT(a_capture_in_idle, clk, rst_n, dp_cmd.capture |-> (state_reg == ST_IDLE && in_valid))

endmodule

FILE: rtl/mpfd_datapath.sv
// ----------------------------------------------------------------------------
// mpfd_datapath
// Frame store with clipping unit, byte walker and read-modify-write stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpfd_datapath #(
    parameter int SCREEN_WIDTH  = mpfd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpfd_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  mpfd_pkg::dp_cmd_t                           dp_cmd,
    output mpfd_pkg::dp_status_t                        dp_status,
    input  logic signed [mpfd_pkg::COORD_W-1:0]         x_pos,
    input  logic signed [mpfd_pkg::COORD_W-1:0]         y_pos,
    input  logic signed [mpfd_pkg::COORD_W-1:0]         span_width,
    input  logic signed [mpfd_pkg::COORD_W-1:0]         span_height,
    input  logic                                        ink,
    input  logic [mpfd_pkg::INDEX_W-1:0]                byte_index,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [mpfd_pkg::PIXEL_W-1:0]                pixel_byte
);
    import mpfd_pkg::*;

    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(SCREEN_WIDTH);
    localparam int PGW         = $clog2(PAGES + 1);

    localparam logic signed [GW-1:0] ZERO_G = '0;
    localparam logic signed [GW-1:0] ONE_G  = GW'(1);
    localparam logic signed [GW-1:0] W_G    = GW'(SCREEN_WIDTH);
    localparam logic signed [GW-1:0] H_G    = GW'(SCREEN_HEIGHT);

    // captured command
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] w_reg;
    logic signed [COORD_W-1:0] h_reg;
    logic                      ink_reg;
    logic [INDEX_W-1:0]        bidx_reg;
    logic                      in_range_reg;

    // clip stage
    logic signed [GW-1:0] xs, ys, ws, hs;
    logic signed [GW-1:0] gx, gy, gw, gh;
    logic signed [GW-1:0] x_end, y_end;
    logic signed [GW-1:0] clo_next, chi_next, rlo_next, rhi_next;
    logic signed [GW-1:0] clo_reg, chi_reg, rlo_reg, rhi_reg;
    logic signed [GW-1:0] chi_m1, rhi_m1;

    // byte walker
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_lo_reg;
    logic [CW-1:0]  col_last_reg;
    logic [PGW-1:0] page_reg;
    logic [PGW-1:0] page_lo_reg;
    logic [PGW-1:0] page_last_reg;
    logic [2:0]     lo_bit_reg;
    logic [2:0]     hi_bit_reg;
    logic [AW-1:0]  base_reg;
    logic           all_reg;
    logic [AW-1:0]  walk_addr;
    logic [PGW-1:0] page_start;
    logic [7:0]     lo_mask;
    logic [7:0]     hi_mask;
    logic [7:0]     walk_mask;

    // store and write stage
    logic [PIXEL_W-1:0] mem [STORE_BYTES];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_valid_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [7:0]         wr_mask_reg;
    logic [PIXEL_W-1:0] wr_data;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIXEL_W-1:0] pixel_byte_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            x_reg        <= x_pos;
            y_reg        <= y_pos;
            w_reg        <= span_width;
            h_reg        <= span_height;
            bidx_reg     <= byte_index;
            in_range_reg <= 32'(byte_index) < STORE_BYTES;
        end
        if (dp_cmd.capture)
        begin
            ink_reg <= ink;
        end
        else if (dp_cmd.init)
        begin
            ink_reg <= 1'b0;
        end
    end

    always_comb
    begin
        xs = GW'(x_reg);
        ys = GW'(y_reg);
        ws = GW'(w_reg);
        hs = GW'(h_reg);
        gx = xs;
        gy = ys;
        gw = ws;
        gh = hs;
        case (dp_cmd.seg)
            SEG_TOP:
            begin
                gh = ONE_G;
            end
            SEG_BOTTOM:
            begin
                gy = ys + hs - ONE_G;
                gh = ONE_G;
            end
            SEG_LEFT:
            begin
                gw = ONE_G;
            end
            SEG_RIGHT:
            begin
                gx = xs + ws - ONE_G;
                gw = ONE_G;
            end
            SEG_DOT:
            begin
                gw = ONE_G;
                gh = ONE_G;
            end
            default:
            begin
            end
        endcase
        x_end    = gx + gw;
        y_end    = gy + gh;
        clo_next = (gx < ZERO_G) ? ZERO_G : gx;
        chi_next = (x_end > W_G) ? W_G : x_end;
        rlo_next = (gy < ZERO_G) ? ZERO_G : gy;
        rhi_next = (y_end > H_G) ? H_G : y_end;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.clip)
        begin
            clo_reg <= clo_next;
            chi_reg <= chi_next;
            rlo_reg <= rlo_next;
            rhi_reg <= rhi_next;
        end
    end

    assign chi_m1     = chi_reg - ONE_G;
    assign rhi_m1     = rhi_reg - ONE_G;
    assign page_start = PGW'(rlo_reg >>> PAGE_SHIFT);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_all)
        begin
            col_reg       <= '0;
            col_lo_reg    <= '0;
            col_last_reg  <= CW'(SCREEN_WIDTH - 1);
            page_reg      <= '0;
            page_lo_reg   <= '0;
            page_last_reg <= PGW'(PAGES - 1);
            lo_bit_reg    <= '0;
            hi_bit_reg    <= BIT_LAST;
            base_reg      <= '0;
            all_reg       <= 1'b1;
        end
        else if (dp_cmd.start)
        begin
            col_reg       <= CW'(clo_reg);
            col_lo_reg    <= CW'(clo_reg);
            col_last_reg  <= CW'(chi_m1);
            page_reg      <= page_start;
            page_lo_reg   <= page_start;
            page_last_reg <= PGW'(rhi_m1 >>> PAGE_SHIFT);
            lo_bit_reg    <= rlo_reg[2:0];
            hi_bit_reg    <= rhi_m1[2:0];
            base_reg      <= AW'(32'(page_start) * SCREEN_WIDTH);
            all_reg       <= 1'b0;
        end
        else if (dp_cmd.step)
        begin
            if (col_reg == col_last_reg)
            begin
                col_reg  <= col_lo_reg;
                page_reg <= page_reg + PGW'(1);
                base_reg <= base_reg + AW'(SCREEN_WIDTH);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    assign walk_addr = base_reg + AW'(col_reg);
    assign lo_mask   = (page_reg == page_lo_reg) ? 8'(BYTE_ALL << lo_bit_reg) : BYTE_ALL;
    assign hi_mask   = (page_reg == page_last_reg)
                       ? 8'(BYTE_ALL >> (BIT_LAST - hi_bit_reg)) : BYTE_ALL;
    assign walk_mask = all_reg ? BYTE_ALL : (lo_mask & hi_mask);

    assign dp_status.empty    = (clo_reg >= chi_reg) || (rlo_reg >= rhi_reg);
    assign dp_status.last     = (col_reg == col_last_reg) && (page_reg == page_last_reg);
    assign dp_status.out_free = !out_valid_reg || out_ready;

    // read one byte ahead, merge and write back the cycle after
    assign rd_addr = dp_cmd.read_issue ? AW'(bidx_reg) : walk_addr;
    assign wr_data = ink_reg ? (rd_data_reg | wr_mask_reg) : (rd_data_reg & ~wr_mask_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= dp_cmd.step;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= walk_addr;
        wr_mask_reg <= walk_mask;
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid_reg)
        begin
            mem[wr_addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            pixel_byte_reg <= in_range_reg ? rd_data_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_byte_reg;

    `MPFD_ASSERT(a_walk_in_store, clk, rst_n, dp_cmd.step |-> (32'(walk_addr) < STORE_BYTES))
    `MPFD_ASSERT(a_no_rmw_hazard, clk, rst_n, (wr_valid_reg && dp_cmd.step) |-> (walk_addr != wr_addr_reg))
    `MPFD_ASSERT(a_read_after_write, clk, rst_n, dp_cmd.read_issue |-> !wr_valid_reg)
    `MPFD_ASSERT(a_out_hold, clk, rst_n, (out_valid_reg && !out_ready) |-> !dp_cmd.out_load)

endmodule

FILE: rtl/mono_page_framebuffer_drawer.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_drawer
// One-bit-per-pixel page framebuffer with clear, pixel, line, rectangle and
// byte read-back commands.
//
//   channel  role    carries
//   cmd      sink    mode, x_pos, y_pos, span_width, span_height, ink, byte_index
//   rsp      source  pixel_byte (read command only)
//
// Items are accepted in the idle state. Per clipped rectangle (outline: four),
// a drawing command runs a clip step, a start step and one walk step per store
// byte touched. Clear walks all SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes;
// read issues its address, then loads the byte. Reset starts a clearing pass.
// A read holds in its data state while the previous result is still waiting.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_drawer #(
    parameter int SCREEN_WIDTH  = mpfd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpfd_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mpfd_in_if.sink     cmd,
    mpfd_out_if.source  rsp
);
    import mpfd_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    mpfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_mode   (cmd.mode),
        .in_ready  (cmd.ready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    mpfd_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .x_pos       (cmd.x_pos),
        .y_pos       (cmd.y_pos),
        .span_width  (cmd.span_width),
        .span_height (cmd.span_height),
        .ink         (cmd.ink),
        .byte_index  (cmd.byte_index),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .pixel_byte  (rsp.pixel_byte)
    );

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mono_page_framebuffer_drawer. Commands go in through
// the command channel; a shadow copy of the page framebuffer is updated as
// each item is accepted, and every byte read back is compared with it. A few
// directed items come first, then random command streams under changing
// backpressure on both channels.
// ----------------------------------------------------------------------------
module tb;
    import mpfd_pkg::*;

    localparam int SCR_W       = SCREEN_WIDTH_DEF;
    localparam int SCR_H       = SCREEN_HEIGHT_DEF;
    localparam int PAGES       = (SCR_H + 7) / 8;
    localparam int STORE_BYTES = SCR_W * PAGES;
    localparam int DRAIN_CYCLES = 1100;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic signed [COORD_W-1:0] span_width;
        logic signed [COORD_W-1:0] span_height;
        logic                      ink;
        logic [INDEX_W-1:0]        byte_index;
    } draw_cmd_t;

    logic clk;
    logic rst_n;

    int send_gap_pct;
    int rcv_gap_pct;
    int err_count;

    logic [PIXEL_W-1:0] shadow_frame [STORE_BYTES];
    logic [PIXEL_W-1:0] pending_bytes [$];
    logic [PIXEL_W-1:0] byte_want;

    mpfd_in_if  cmd_if ();
    mpfd_out_if rsp_if ();

    mono_page_framebuffer_drawer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= ($urandom_range(99) >= rcv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("pixel_byte: expected none, actual %02h", rsp_if.pixel_byte);
                err_count++;
            end
            else
            begin
                byte_want = pending_bytes.pop_front();
                if (rsp_if.pixel_byte !== byte_want)
                begin
                    $error("pixel_byte: expected %02h, actual %02h",
                           byte_want, rsp_if.pixel_byte);
                    err_count++;
                end
            end
        end
    end

    function automatic void plot_pixel(int x, int y, logic ink);
        int idx;
        if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
            return;
        idx = (y / 8) * SCR_W + x;
        shadow_frame[idx][y % 8] = ink;
    endfunction

    function automatic void plot_row(int x, int y, int w, logic ink);
        int lo;
        int hi;
        if (w <= 0 || y < 0 || y >= SCR_H)
            return;
        lo = (x < 0) ? 0 : x;
        hi = (x + w > SCR_W) ? SCR_W : x + w;
        for (int c = lo; c < hi; c++)
            plot_pixel(c, y, ink);
    endfunction

    function automatic void plot_column(int x, int y, int h, logic ink);
        int lo;
        int hi;
        if (h <= 0 || x < 0 || x >= SCR_W)
            return;
        lo = (y < 0) ? 0 : y;
        hi = (y + h > SCR_H) ? SCR_H : y + h;
        for (int r = lo; r < hi; r++)
            plot_pixel(x, r, ink);
    endfunction

    function automatic void apply_draw_cmd(draw_cmd_t c);
        int x;
        int y;
        int w;
        int h;
        int lo;
        int hi;
        x = int'($signed(c.x_pos));
        y = int'($signed(c.y_pos));
        w = int'($signed(c.span_width));
        h = int'($signed(c.span_height));
        case (c.mode)
            MODE_CLEAR:
                foreach (shadow_frame[i])
                    shadow_frame[i] = {PIXEL_W{c.ink}};
            MODE_PIXEL:
                plot_pixel(x, y, c.ink);
            MODE_HLINE:
                plot_row(x, y, w, c.ink);
            MODE_VLINE:
                plot_column(x, y, h, c.ink);
            MODE_OUTLINE:
            begin
                plot_row(x, y, w, c.ink);
                plot_row(x, y + h - 1, w, c.ink);
                plot_column(x, y, h, c.ink);
                plot_column(x + w - 1, y, h, c.ink);
            end
            MODE_FILL:
            begin
                if (w > 0 && h > 0)
                begin
                    lo = (y < 0) ? 0 : y;
                    hi = (y + h > SCR_H) ? SCR_H : y + h;
                    for (int r = lo; r < hi; r++)
                        plot_row(x, r, w, c.ink);
                end
            end
            MODE_READ:
                pending_bytes.push_back((c.byte_index < STORE_BYTES) ?
                                        shadow_frame[c.byte_index] : '0);
            default: ;
        endcase
    endfunction

    function automatic draw_cmd_t make_cmd(logic [MODE_W-1:0] mode, int x, int y,
                                           int w, int h, logic ink, int idx);
        draw_cmd_t c;
        c.mode        = mode;
        c.x_pos       = COORD_W'(x);
        c.y_pos       = COORD_W'(y);
        c.span_width  = COORD_W'(w);
        c.span_height = COORD_W'(h);
        c.ink         = ink;
        c.byte_index  = INDEX_W'(idx);
        return c;
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int pick;
        pick          = int'($urandom_range(99));
        c.x_pos       = COORD_W'($urandom);
        c.y_pos       = COORD_W'($urandom);
        c.span_width  = COORD_W'($urandom);
        c.span_height = COORD_W'($urandom);
        c.ink         = 1'($urandom_range(1));
        c.byte_index  = INDEX_W'($urandom_range(1023));
        if (pick < 30)
            c.mode = MODE_READ;
        else if (pick < 44)
            c.mode = MODE_PIXEL;
        else if (pick < 57)
            c.mode = MODE_HLINE;
        else if (pick < 70)
            c.mode = MODE_VLINE;
        else if (pick < 83)
            c.mode = MODE_OUTLINE;
        else if (pick < 95)
            c.mode = MODE_FILL;
        else if (pick < 97)
            c.mode = MODE_CLEAR;
        else
            c.mode = MODE_UNUSED;
        if ($urandom_range(9) != 0)
        begin
            c.x_pos = COORD_W'($urandom_range(SCR_W + 40) - 20);
            c.y_pos = COORD_W'($urandom_range(SCR_H + 40) - 20);
            if ($urandom_range(7) == 0)
            begin
                c.span_width  = COORD_W'($urandom_range(SCR_W + 32) - 8);
                c.span_height = COORD_W'($urandom_range(SCR_H + 16) - 8);
            end
            else
            begin
                c.span_width  = COORD_W'($urandom_range(27) - 3);
                c.span_height = COORD_W'($urandom_range(27) - 3);
            end
        end
        return c;
    endfunction

    task automatic send_cmd(input draw_cmd_t c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.mode        <= c.mode;
        cmd_if.x_pos       <= c.x_pos;
        cmd_if.y_pos       <= c.y_pos;
        cmd_if.span_width  <= c.span_width;
        cmd_if.span_height <= c.span_height;
        cmd_if.ink         <= c.ink;
        cmd_if.byte_index  <= c.byte_index;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        apply_draw_cmd(c);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_bytes.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_reset_contents();
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
    endtask

    task automatic test_pixels();
        send_cmd(make_cmd(MODE_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        send_cmd(make_cmd(MODE_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 1'b1, 0));
        send_cmd(make_cmd(MODE_PIXEL, -1, 0, 0, 0, 1'b1, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
    endtask

    task automatic test_lines();
        send_cmd(make_cmd(MODE_HLINE, -5, 10, 20, 0, 1'b1, 0));
        send_cmd(make_cmd(MODE_HLINE, -32768, 3, 32767, 0, 1'b1, 0));
        send_cmd(make_cmd(MODE_VLINE, 5, -3, 0, 12, 1'b1, 0));
        send_cmd(make_cmd(MODE_VLINE, 6, 0, 0, -32768, 1'b1, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, SCR_W + 5));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, 5));
    endtask

    task automatic test_rectangles();
        send_cmd(make_cmd(MODE_OUTLINE, SCR_W - 8, SCR_H - 4, 20, 0, 1'b1, 0));
        send_cmd(make_cmd(MODE_OUTLINE, 10, 20, 1, 1, 1'b1, 0));
        send_cmd(make_cmd(MODE_FILL, 32767, 32767, 32767, 32767, 1'b1, 0));
        send_cmd(make_cmd(MODE_FILL, 40, 12, 9, 9, 1'b1, 0));
        send_cmd(make_cmd(MODE_FILL, -32768, -32768, 32767, -32768, 1'b1, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, (PAGES - 1) * SCR_W + SCR_W - 8));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, SCR_W + 44));
    endtask

    task automatic test_clear_and_unused();
        send_cmd(make_cmd(MODE_UNUSED, 3, 3, 4, 4, 1'b1, 300));
        send_cmd(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 1'b1, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, 300));
        send_cmd(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, 300));
    endtask

    task automatic test_random(input int src_pct, input int dst_pct, input int count);
        send_gap_pct = src_pct;
        rcv_gap_pct  = dst_pct;
        repeat (count)
            send_cmd(random_cmd());
        hold_until_drained();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        err_count          = 0;
        send_gap_pct       = 37;
        rcv_gap_pct        = 51;
        cmd_if.valid       = 1'b0;
        cmd_if.mode        = MODE_CLEAR;
        cmd_if.x_pos       = '0;
        cmd_if.y_pos       = '0;
        cmd_if.span_width  = '0;
        cmd_if.span_height = '0;
        cmd_if.ink         = 1'b0;
        cmd_if.byte_index  = '0;
        foreach (shadow_frame[i])
            shadow_frame[i] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_contents();
        test_pixels();
        test_lines();
        test_rectangles();
        test_clear_and_unused();
        hold_until_drained();

        test_random(37, 51, 470);
        test_random(51, 37, 470);
        test_random(0, 0, 470);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #150_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/mpfd_pkg.sv
rtl/mpfd_in_if.sv
rtl/mpfd_out_if.sv
rtl/mpfd_ctrl.sv
rtl/mpfd_datapath.sv
rtl/mono_page_framebuffer_drawer.sv
bench/tb.sv
